// ===== rtl/cpps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpps_pkg
// Shared widths, codes and control types for the closest path point search.
// ----------------------------------------------------------------------------
package cpps_pkg;

  // defaults for the top level parameters
  localparam int PATH_MAX_DEF   = 1024;
  localparam int COORD_BITS_DEF = 12;

  // fixed field widths
  localparam int OP_W      = 1;
  localparam int PIDX_W    = 10;
  localparam int POS_W     = 12;
  localparam int LEN_W     = 11;
  localparam int LD_W      = 26;
  localparam int CFG_W     = 26;
  localparam int REG_IDX_W = 1;

  // register reset values and search constants
  localparam int LEN_RESET       = 1024;
  localparam int LOOKAHEAD_RESET = 2500;
  localparam int MIN_START       = 999999;

  // item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATH_LENGTH = 1'b0,
    REG_LOOKAHEAD   = 1'b1
  } reg_idx_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_PUBLISH
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic start;
    logic run;
    logic publish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic found;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/cpps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpps_ctrl
// Controller: takes items, sequences a search and hands the result to the
// output register once the receiver has room.
// ----------------------------------------------------------------------------
module cpps_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cpps_pkg::OP_W-1:0]    operation,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cpps_pkg::cmd_t               cmd,
  input  cpps_pkg::status_t            status
);
  import cpps_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (operation == OP_QUERY)) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (status.found) state_next = S_PUBLISH;
      end
      S_PUBLISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = accept && (operation == OP_LOAD);
        cmd.start = accept && (operation == OP_QUERY);
      end
      S_SEARCH: begin
        cmd.run = 1'b1;
      end
      S_PUBLISH: begin
        cmd.publish = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // output item valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cpps_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpps_datapath
// Path point memory, configuration registers and a three stage distance
// pipeline (read, square, sum and compare) walking down from the last point.
// ----------------------------------------------------------------------------
module cpps_datapath #(
  parameter int PATH_MAX   = cpps_pkg::PATH_MAX_DEF,
  parameter int COORD_BITS = cpps_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cpps_pkg::cmd_t                 cmd,
  output cpps_pkg::status_t              status,
  input  logic                           cfg_we,
  input  logic [cpps_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [cpps_pkg::CFG_W-1:0]     cfg_data,
  input  logic [cpps_pkg::PIDX_W-1:0]    point_index,
  input  logic [cpps_pkg::POS_W-1:0]     pos_x,
  input  logic [cpps_pkg::POS_W-1:0]     pos_y,
  output logic [cpps_pkg::PIDX_W-1:0]    path_index
);
  import cpps_pkg::*;

  localparam int IDX_W  = (PATH_MAX > 1) ? $clog2(PATH_MAX) : 1;
  localparam int CMP_W  = ((IDX_W + 1) > LEN_W) ? (IDX_W + 1) : LEN_W;
  localparam int SLOT_W = ((IDX_W + 1) > PIDX_W) ? (IDX_W + 1) : PIDX_W;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int D_W    = ((SQ_W + 1) > LD_W) ? (SQ_W + 1) : LD_W;

  // configuration registers
  logic [LEN_W-1:0] path_length;
  logic [LD_W-1:0]  lookahead_dist_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      path_length       <= LEN_W'(LEN_RESET);
      lookahead_dist_sq <= LD_W'(LOOKAHEAD_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATH_LENGTH: path_length       <= cfg_data[LEN_W-1:0];
        REG_LOOKAHEAD:   lookahead_dist_sq <= cfg_data[LD_W-1:0];
        default:         path_length       <= path_length;
      endcase
    end
  end

  // path length clamped to one..PATH_MAX, search starts at its last point
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] len_eff;
  logic [IDX_W-1:0] start_addr;

  always_comb begin
    len_ext = CMP_W'(path_length);
    if (len_ext == '0) begin
      len_eff = CMP_W'(1);
    end else if (len_ext > CMP_W'(PATH_MAX)) begin
      len_eff = CMP_W'(PATH_MAX);
    end else begin
      len_eff = len_ext;
    end
    start_addr = IDX_W'(len_eff - CMP_W'(1));
  end

  // point memory, x in the upper half and y in the lower half
  logic [SQ_W-1:0]  mem [PATH_MAX];
  logic [SQ_W-1:0]  mem_q;
  logic [IDX_W-1:0] rd_addr;
  logic             slot_ok;

  assign slot_ok = SLOT_W'(point_index) < SLOT_W'(PATH_MAX);

  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok) begin
      mem[IDX_W'(point_index)] <= {COORD_BITS'(pos_x), COORD_BITS'(pos_y)};
    end
    mem_q <= mem[rd_addr];
  end

  // car position for the running query
  logic [COORD_BITS-1:0] car_x;
  logic [COORD_BITS-1:0] car_y;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      car_x <= COORD_BITS'(pos_x);
      car_y <= COORD_BITS'(pos_y);
    end
  end

  // read issue, one address per cycle down to index zero
  logic issue_on;
  logic issue_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_on <= 1'b0;
    end else if (cmd.start) begin
      issue_on <= 1'b1;
    end else if (cmd.run && issue_on && (rd_addr == '0)) begin
      issue_on <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_addr     <= start_addr;
      issue_first <= 1'b1;
    end else if (cmd.run && issue_on) begin
      rd_addr     <= rd_addr - IDX_W'(1);
      issue_first <= 1'b0;
    end
  end

  // pipeline valid flags, flushed whenever the search is not running
  logic s1_valid;
  logic s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.run && issue_on;
      s2_valid <= cmd.run && s1_valid;
    end
  end

  // stage one: absolute differences and squares
  logic [IDX_W-1:0]      s1_idx;
  logic                  s1_first;
  logic [COORD_BITS-1:0] px;
  logic [COORD_BITS-1:0] py;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [IDX_W-1:0]      s2_idx;
  logic                  s2_first;
  logic [SQ_W-1:0]       sq_x;
  logic [SQ_W-1:0]       sq_y;

  always_comb begin
    px = mem_q[SQ_W-1:COORD_BITS];
    py = mem_q[COORD_BITS-1:0];
    dx = (px > car_x) ? (px - car_x) : (car_x - px);
    dy = (py > car_y) ? (py - car_y) : (car_y - py);
  end

  always_ff @(posedge clk) begin
    s1_idx   <= rd_addr;
    s1_first <= issue_first;
    s2_idx   <= s1_idx;
    s2_first <= s1_first;
    sq_x     <= SQ_W'(dx) * SQ_W'(dx);
    sq_y     <= SQ_W'(dy) * SQ_W'(dy);
  end

  // stage two: sum, running minimum and stop test
  logic [D_W-1:0]   dist_sum;
  logic             eval;
  logic             upd;
  logic             stop;
  logic [D_W-1:0]   best;
  logic [IDX_W-1:0] best_idx;
  logic [IDX_W-1:0] final_idx;

  always_comb begin
    dist_sum = D_W'(sq_x) + D_W'(sq_y);
    eval     = cmd.run && s2_valid;
    upd      = !s2_first && (dist_sum < best);
    stop     = (dist_sum <= D_W'(lookahead_dist_sq)) || (s2_idx == '0);
  end

  assign status.found = eval && stop;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best     <= D_W'(MIN_START);
      best_idx <= '0;
    end else if (eval && upd) begin
      best     <= dist_sum;
      best_idx <= s2_idx;
    end
  end

  // selected index: the stop point unless it is zero, else the minimum
  always_ff @(posedge clk) begin
    if (eval && stop) begin
      if (s2_idx != '0) begin
        final_idx <= s2_idx;
      end else if (upd) begin
        final_idx <= '0;
      end else begin
        final_idx <= best_idx;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      path_index <= PIDX_W'(final_idx);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/closest_path_point_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// closest_path_point_search
// Stores a path of points and, per query, finds the path point to steer to.
//
// Usage: items come in on in_valid/in_ready. A load item (operation 0)
// writes pos_x/pos_y to slot point_index and gives no result;
// slots at or beyond PATH_MAX are ignored. A query item (operation 1) gives
// the car position and yields one path_index on out_valid/out_ready.
// The search reads one stored point per cycle from the point memory, from
// the last point in use toward index zero, stopping at the first point
// within the look-ahead distance. A query visits from one point up to the
// clamped path length; in_ready is low from its acceptance until its
// result goes to the output register, and loads are taken back to back.
// A result that the receiver does not take waits in the output register;
// a new item may be accepted meanwhile, and a following query holds its
// result until the register is free. Reset empties the output register,
// returns the controller to idle and sets path_length to 1024 and
// lookahead_dist_sq to 2500; path points are undefined until loaded.
// The user writes registers on cfg_we with cfg_index 0 (path_length) or 1
// (lookahead_dist_sq) only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module closest_path_point_search #(
  parameter int PATH_MAX   = cpps_pkg::PATH_MAX_DEF,
  parameter int COORD_BITS = cpps_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cpps_pkg::OP_W-1:0]      operation,
  input  logic [cpps_pkg::PIDX_W-1:0]    point_index,
  input  logic [cpps_pkg::POS_W-1:0]     pos_x,
  input  logic [cpps_pkg::POS_W-1:0]     pos_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cpps_pkg::PIDX_W-1:0]    path_index,
  input  logic                           cfg_we,
  input  logic [cpps_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [cpps_pkg::CFG_W-1:0]     cfg_data
);
  import cpps_pkg::*;

  cmd_t    cmd;
  status_t status;

  // controller
  cpps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // datapath
  cpps_datapath #(
    .PATH_MAX   (PATH_MAX),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .point_index (point_index),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .path_index  (path_index)
  );

  // a query occupies the block at least until its search is done
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (operation == OP_QUERY)) |=> !in_ready)
    else $error("block took another item right after a query");

  // a load never blocks the input
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (operation == OP_LOAD)) |=> in_ready)
    else $error("load item stalled the input");

  // a new result only appears at the end of a search
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a running search");

endmodule
`default_nettype wire
